/* hw/rtl/ilh_pkg.sv */
// shared types and constants for the implicit list heap allocator
`timescale 1ns / 1ps
package ilh_pkg;

  localparam int DEFAULT_HEAP_BYTES = 16;
  localparam int DATA_W = 8;
  // wide enough for a heap position plus a header size
  localparam int SUM_W = 9;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_ALLOCATED   = 3'd0;
  localparam logic [2:0] ST_NO_SPACE    = 3'd1;
  localparam logic [2:0] ST_FREED       = 3'd2;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
  localparam logic [2:0] ST_NULL        = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] request_size;
    logic [6:0] release_index;
  } ilh_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] payload_index;
    logic [7:0] block_bytes;
  } ilh_rsp_t;

endpackage

/* hw/rtl/ilh_ram.sv */
// heap byte memory, one write port and one registered read port
`timescale 1ns / 1ps
module ilh_ram import ilh_pkg::*; #(
  parameter int HEAP_BYTES = DEFAULT_HEAP_BYTES,
  parameter int AW = $clog2(HEAP_BYTES)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [HEAP_BYTES];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ilh_ctrl.sv */
// request sequencer: header walk for allocate, forward merge for free
`timescale 1ns / 1ps
module ilh_ctrl import ilh_pkg::*; #(
  parameter int HEAP_BYTES = DEFAULT_HEAP_BYTES,
  parameter int AW = $clog2(HEAP_BYTES),
  parameter int PW = $clog2(HEAP_BYTES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ilh_req_t          req_i,
  output logic              done_o,
  output ilh_rsp_t          rsp_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [DATA_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_SPLIT,
    S_F_HDR,
    S_F_CHK
  } state_e;

  localparam logic [DATA_W-1:0] HEAP_HDR = DATA_W'(HEAP_BYTES) & ~DATA_W'(1);
  localparam logic [SUM_W-1:0]  HEAP_SZ  = SUM_W'(HEAP_BYTES);
  localparam logic [PW-1:0]     LAST_POS = PW'(HEAP_BYTES - 1);

  state_e            state_q, state_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] total_q, total_d;
  logic [SUM_W-1:0]  need_q, need_d;
  logic [6:0]        idx_q, idx_d;
  logic              done_q, done_d;
  ilh_rsp_t          rsp_q, rsp_d;

  logic [DATA_W-1:0] bsize;
  logic [SUM_W-1:0]  pos_ext;
  logic [SUM_W-1:0]  blk_end;
  logic [SUM_W-1:0]  tail;
  logic [SUM_W-1:0]  next_end;
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] rest;
  logic [SUM_W-1:0]  idx_m1;
  logic              fits;

  assign bsize    = mem_rdata_i & ~DATA_W'(1);
  assign pos_ext  = SUM_W'(pos_q);
  assign blk_end  = pos_ext + SUM_W'(bsize);
  assign tail     = pos_ext + SUM_W'(total_q);
  assign next_end = tail + SUM_W'(bsize);
  assign merged   = total_q + bsize;
  assign rest     = bsize - need_q[DATA_W-1:0];
  assign idx_m1   = SUM_W'(req_i.release_index) - SUM_W'(1);
  assign fits     = !mem_rdata_i[0] && (SUM_W'(bsize) >= need_q);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    total_d     = total_q;
    need_d      = need_q;
    idx_d       = idx_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[AW-1:0];
        mem_wdata_o = (pos_q == '0) ? HEAP_HDR : '0;
        if (pos_q == LAST_POS) begin
          pos_d   = '0;
          state_d = S_IDLE;
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          idx_d = req_i.release_index;
          if (req_i.command == CMD_FREE) begin
            if (req_i.release_index == '0) begin
              done_d = 1'b1;
              rsp_d  = '{status: ST_NULL, payload_index: '0, block_bytes: '0};
            end else if (idx_m1 >= HEAP_SZ) begin
              done_d = 1'b1;
              rsp_d  = '{status: ST_DOUBLE_FREE, payload_index: req_i.release_index,
                         block_bytes: '0};
            end else begin
              pos_d       = PW'(idx_m1);
              mem_re_o    = 1'b1;
              mem_raddr_o = idx_m1[AW-1:0];
              state_d     = S_F_HDR;
            end
          end else begin
            // odd sizes round up by one, even sizes by two
            need_d      = SUM_W'(req_i.request_size | 8'd1) + SUM_W'(1);
            pos_d       = '0;
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            state_d     = S_A_CHK;
          end
        end
      end

      S_A_CHK: begin
        if (bsize == '0 || blk_end > HEAP_SZ) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_NO_SPACE, payload_index: '0, block_bytes: '0};
          state_d = S_IDLE;
        end else if (fits) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q[AW-1:0];
          mem_wdata_o = need_q[DATA_W-1:0] | DATA_W'(1);
          rsp_d = '{status: ST_ALLOCATED, payload_index: 7'(pos_ext + SUM_W'(1)),
                    block_bytes: need_q[DATA_W-1:0]};
          if (rest != '0) begin
            pos_d   = PW'(pos_ext + need_q);
            total_d = rest;
            state_d = S_A_SPLIT;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (blk_end >= HEAP_SZ) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_NO_SPACE, payload_index: '0, block_bytes: '0};
          state_d = S_IDLE;
        end else begin
          pos_d       = PW'(blk_end);
          mem_re_o    = 1'b1;
          mem_raddr_o = blk_end[AW-1:0];
        end
      end

      S_A_SPLIT: begin
        // free header for the remainder behind the new block
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[AW-1:0];
        mem_wdata_o = total_q;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end

      S_F_HDR: begin
        if (!mem_rdata_i[0]) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_DOUBLE_FREE, payload_index: idx_q, block_bytes: '0};
          state_d = S_IDLE;
        end else if (blk_end >= HEAP_SZ) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q[AW-1:0];
          mem_wdata_o = bsize;
          done_d      = 1'b1;
          rsp_d       = '{status: ST_FREED, payload_index: idx_q, block_bytes: bsize};
          state_d     = S_IDLE;
        end else begin
          total_d     = bsize;
          mem_re_o    = 1'b1;
          mem_raddr_o = blk_end[AW-1:0];
          state_d     = S_F_CHK;
        end
      end

      S_F_CHK: begin
        // stop at a used or empty header, or one that runs past the end
        if (mem_rdata_i[0] || bsize == '0 || next_end > HEAP_SZ) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q[AW-1:0];
          mem_wdata_o = total_q & ~DATA_W'(1);
          done_d      = 1'b1;
          rsp_d       = '{status: ST_FREED, payload_index: idx_q, block_bytes: total_q};
          state_d     = S_IDLE;
        end else if (next_end >= HEAP_SZ) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q[AW-1:0];
          mem_wdata_o = merged & ~DATA_W'(1);
          done_d      = 1'b1;
          rsp_d       = '{status: ST_FREED, payload_index: idx_q, block_bytes: merged};
          state_d     = S_IDLE;
        end else begin
          total_d     = merged;
          mem_re_o    = 1'b1;
          mem_raddr_o = next_end[AW-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    need_q  <= need_d;
    idx_q   <= idx_d;
    rsp_q   <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* hw/rtl/implicit_list_heap_allocator.sv */
// top level of the implicit list heap allocator
`timescale 1ns / 1ps
// First-fit byte heap allocator. A request is taken when start is high and
// busy is low; its result appears on rsp_o when done_o is high for exactly
// one cycle, and must be captured then. All heap headers live in one memory
// with a single registered read port, so the walk reads one header at a
// time. An allocate visits headers from the start of the heap, writes the
// header of the block it takes, and writes a split header behind it when a
// remainder is left; a free reads the freed block's header, then the headers
// behind it, merging those that are free, and a null or out-of-range free is
// answered without a memory read. After reset busy stays high while the
// memory is written to its initial image.
module implicit_list_heap_allocator import ilh_pkg::*; #(
  parameter int HEAP_BYTES = DEFAULT_HEAP_BYTES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ilh_req_t req_i,
  output logic     done_o,
  output ilh_rsp_t rsp_o
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int PW = $clog2(HEAP_BYTES + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  ilh_ctrl #(
    .HEAP_BYTES(HEAP_BYTES),
    .AW        (AW),
    .PW        (PW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  ilh_ram #(
    .HEAP_BYTES(HEAP_BYTES),
    .AW        (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
